// ----- src/motor_speed_ramp_generator_unit_defines.svh -----
// Assertion macros used by the speed ramp generator core (msrg_core).
`ifndef MOTOR_SPEED_RAMP_GENERATOR_UNIT_DEFINES_SVH
`define MOTOR_SPEED_RAMP_GENERATOR_UNIT_DEFINES_SVH

// Checked property, ignored while reset is held.
`define MSRG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property, also sampled during reset.
`define MSRG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/msrg_pkg.sv -----
// Shared types, constants and register codes of the speed ramp generator.
package msrg_pkg;

    localparam int UNITS_W  = 12;
    localparam int SPEED_W  = 19;
    localparam int TABLE_N  = 5;

    localparam logic [SPEED_W-1:0] SPEED_MAX_H = 19'd409500;
    localparam logic [SPEED_W-1:0] STEP_DOWN_H = 19'd50;
    localparam logic [SPEED_W-1:0] CREEP_H     = 19'd2;
    localparam logic [SPEED_W-1:0] BAND_H      = 19'd100;
    localparam logic [SPEED_W-1:0] HUNDRED     = 19'd100;

    localparam logic [UNITS_W-1:0] MIDDLE_RESET = 12'd2048;

    // Fraction of the way from middle to target, in percent, and its step.
    localparam logic [6:0] FRAC_PCT [TABLE_N] = '{7'd15, 7'd30, 7'd50, 7'd75, 7'd100};
    localparam logic [7:0] STEP_H   [TABLE_N] = '{8'd200, 8'd100, 8'd50, 8'd25, 8'd20};

    typedef enum logic [1:0] {
        REG_MIDDLE_SPEED = 2'd0,
        REG_SLIDE_ENABLE = 2'd1
    } msrg_reg_t;

    // One tick after the input stage: target and table thresholds in hundredths.
    typedef struct packed {
        logic                             accel;
        logic [SPEED_W-1:0]               target_h;
        logic [TABLE_N-1:0][SPEED_W-1:0]  thresh;
    } msrg_item_t;

endpackage

// ----- src/motor_speed_ramp_generator_unit.sv -----
// Speed ramp generator: slews a running speed in hundredths toward each tick's target.
// One tick word enters per cycle while s_tready is high; results pass the input
// register (target scaling and table thresholds), then the ramp step register that
// also holds the running speed. Back-to-back ticks chain through that step register,
// so a full tick rate of one per cycle is sustained while m_tready stays high. The
// configuration must be written via the cfg port with no tick in flight; not enforced.
module motor_speed_ramp_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [11:0] target_speed, [15:12] zero
    input  logic        s_tuser,  // [0] accelerate_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // [18:0] speed_hundredths, [23:19] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import msrg_pkg::*;

    logic [UNITS_W-1:0] middle_reg;
    logic               slide_reg;
    logic               item_valid;
    logic               item_take;
    msrg_item_t         item;
    logic [SPEED_W-1:0] speed_hundredths;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            middle_reg <= MIDDLE_RESET;
            slide_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIDDLE_SPEED: middle_reg <= cfg_data;
                REG_SLIDE_ENABLE: slide_reg  <= cfg_data[0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    msrg_stage u_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .target_speed    (s_tdata[UNITS_W-1:0]),
        .accelerate_mode (s_tuser),
        .middle_speed    (middle_reg),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take)
    );

    msrg_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_valid       (item_valid),
        .item             (item),
        .item_take        (item_take),
        .slide_enable     (slide_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .speed_hundredths (speed_hundredths)
    );

    assign m_tdata = {5'd0, speed_hundredths};

endmodule

// ----- src/msrg_stage.sv -----
// Input register: scales the target and precomputes the table thresholds.
module msrg_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msrg_pkg::UNITS_W-1:0]  target_speed,
    input  logic                          accelerate_mode,
    input  logic [msrg_pkg::UNITS_W-1:0]  middle_speed,
    output logic                          item_valid,
    output msrg_pkg::msrg_item_t          item,
    input  logic                          item_take
);
    import msrg_pkg::*;

    logic       valid_reg;
    msrg_item_t item_reg;
    msrg_item_t item_next;

    // Threshold k is middle*(100-k) + target*k, which always lies in 0..409500.
    always_comb begin
        item_next.accel    = accelerate_mode;
        item_next.target_h = SPEED_W'(SPEED_W'(target_speed) * HUNDRED);
        for (int i = 0; i < TABLE_N; i++) begin
            item_next.thresh[i] =
                SPEED_W'(SPEED_W'(middle_speed) * SPEED_W'(7'd100 - FRAC_PCT[i]))
              + SPEED_W'(SPEED_W'(target_speed) * SPEED_W'(FRAC_PCT[i]));
        end
    end

    assign s_tready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- src/msrg_core.sv -----
// Ramp step: updates the running speed and holds it as the result word.
module msrg_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  msrg_pkg::msrg_item_t          item,
    output logic                          item_take,
    input  logic                          slide_enable,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msrg_pkg::SPEED_W-1:0]  speed_hundredths
);
    import msrg_pkg::*;

    logic               out_valid_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [SPEED_W-1:0] speed_next;
    logic [SPEED_W:0]   s_ext;
    logic [SPEED_W:0]   t_ext;
    logic [SPEED_W:0]   sum;
    logic [7:0]         step;
    logic               found;

    assign s_ext = {1'b0, speed_reg};
    assign t_ext = {1'b0, item.target_h};

    // First threshold the speed lies below picks the step.
    always_comb begin
        step  = 8'd0;
        found = 1'b0;
        for (int i = 0; i < TABLE_N; i++) begin
            if (!found && speed_reg < item.thresh[i]) begin
                step  = STEP_H[i];
                found = 1'b1;
            end
        end
    end

    always_comb begin
        sum        = s_ext + (SPEED_W+1)'(step);
        speed_next = speed_reg;
        if (!slide_enable) begin
            speed_next = item.target_h;
        end else if (item.accel) begin
            if (s_ext + (SPEED_W+1)'(BAND_H) < t_ext) begin
                // Overshoot is allowed; only the range end clips.
                speed_next = (sum > (SPEED_W+1)'(SPEED_MAX_H)) ? SPEED_MAX_H
                                                               : sum[SPEED_W-1:0];
            end else if (s_ext > t_ext + (SPEED_W+1)'(BAND_H)) begin
                speed_next = speed_reg - STEP_DOWN_H;
            end
        end else begin
            if (speed_reg < item.target_h) begin
                // clip the creep at the range end
                if (speed_reg + CREEP_H > SPEED_MAX_H) begin
                    speed_next = SPEED_MAX_H;
                end else begin
                    speed_next = speed_reg + CREEP_H;
                end
            end else if (speed_reg > item.target_h) begin
                speed_next = item.target_h;
            end
        end
    end

    assign item_take        = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid         = out_valid_reg;
    assign speed_hundredths = speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            speed_reg     <= '0;
        end else begin
            if (item_take) begin
                out_valid_reg <= 1'b1;
                speed_reg     <= speed_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`include "motor_speed_ramp_generator_unit_defines.svh"

    `MSRG_ASSERT(a_speed_in_range, speed_reg <= SPEED_MAX_H, "speed beyond range end")
    `MSRG_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !out_valid_reg, "result valid after reset")
    `MSRG_ASSERT(a_state_held_on_stall, (out_valid_reg && !m_tready) |=> $stable(speed_reg), "speed changed while result stalled")
    `MSRG_ASSERT(a_copy_when_no_slide, (item_take && !slide_enable) |=> (speed_reg == $past(item.target_h)), "speed did not copy target")
    `MSRG_ASSERT(a_no_take_on_stall, (out_valid_reg && !m_tready) |-> !item_take, "item taken over a waiting result")

endmodule
